### hdl/emboss_3x3_convolution_assert.svh
// Assertion macros shared by the emboss checker.
`ifndef EMBOSS_3X3_CONVOLUTION_ASSERT_SVH
`define EMBOSS_3X3_CONVOLUTION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define EMB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emboss check failed");

// Next-cycle implication, disabled in reset.
`define EMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emboss check failed");

`endif

### hdl/emb_pkg.sv
`default_nettype none

package emb_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam int unsigned CFG_W   = 12;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned LIM_W   = 14;
    localparam int unsigned COORD_W = 11;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned SUM_W   = 12;
    localparam int unsigned KDIM    = 3;
    localparam int unsigned MIN_DIM = 3;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [CH_W-1:0]         chan_t;
    typedef chan_t [KDIM-1:0]        pixel_t;   // [2] red, [1] green, [0] blue
    typedef pixel_t [KDIM-1:0]       column_t;  // [2] top, [1] middle, [0] bottom
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [KDIM-1:0]         chsum_t;

    typedef struct packed {
        pixel_t             pix;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } result_t;

    // row 0 is the top of the window, column 0 its left side
    localparam logic signed [2:0] KERNEL [KDIM][KDIM] = '{
        '{-3'sd2, -3'sd1,  3'sd0},
        '{-3'sd1,  3'sd1,  3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd2}
    };

    function automatic chsum_t col_sum(column_t c, int unsigned kcol);
        chsum_t acc;
        for (int ch = 0; ch < KDIM; ch++)
        begin
            acc[ch] = '0;
            for (int r = 0; r < KDIM; r++)
            begin
                acc[ch] = acc[ch] + sum_t'($signed({1'b0, c[KDIM-1-r][ch]}))
                                  * sum_t'(KERNEL[r][kcol]);
            end
        end
        return acc;
    endfunction

    function automatic chan_t clamp8(sum_t s);
        chan_t r;
        if (s < 0)
            r = '0;
        else if (s > sum_t'(255))
            r = '1;
        else
            r = s[CH_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/emb_cell.sv
`default_nettype none

module emb_cell #(
    parameter int unsigned KCOL = 0
) (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire emb_pkg::column_t col_in,
    input  wire emb_pkg::chsum_t  psum_in,
    output emb_pkg::column_t      col_out,
    output emb_pkg::chsum_t       psum_out
);
    import emb_pkg::*;

    column_t col_reg;
    chsum_t  own_sum;

    always_ff @(posedge clk)
    begin
        if (shift)
            col_reg <= col_in;
    end

    assign own_sum = col_sum(col_reg, KCOL);

    always_comb
    begin
        for (int ch = 0; ch < KDIM; ch++)
        begin
            psum_out[ch] = psum_in[ch] + own_sum[ch];
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

### hdl/emb_line_buf.sv
`default_nettype none

module emb_line_buf #(
    parameter int unsigned MAX_WIDTH = emb_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire emb_pkg::pixel_t              wr_older,
    input  wire emb_pkg::pixel_t              wr_newer,
    output emb_pkg::pixel_t                   rd_older,
    output emb_pkg::pixel_t                   rd_newer,
    output logic                              clearing
);
    import emb_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    pixel_t older_mem [MAX_WIDTH];
    pixel_t newer_mem [MAX_WIDTH];

    pixel_t          rd_older_reg;
    pixel_t          rd_newer_reg;
    logic            clearing_reg;
    logic            clearing_next;
    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   clr_cnt_next;

    // zeroing sweep after reset, one entry of each buffer per cycle
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MAX_WIDTH - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            older_mem[clr_cnt_reg] <= '0;
            newer_mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

### hdl/emboss_3x3_convolution.sv
// Channel  Handshake             Payload
// cfg      psel/penable/pwrite   paddr, pwdata in; prdata out (pready tied high)
// in       in_valid / in_stall   red_in, green_in, blue_in
// out      out_valid / out_stall red_out, green_out, blue_out, out_row, out_col, frame_last
//
// One pixel per clock while in_stall is low; a result goes from its accepted pixel
// through stage A (line-buffer read) and stage B (window sum) to the output register.
// Each line buffer is a RAM with one read and one write port per cycle.
// After reset in_stall stays high while the line buffers
// are zeroed; register writes are taken meanwhile.
// The output has a two-entry skid; in_stall rises only when both are full.
`default_nettype none

module emboss_3x3_convolution #(
    parameter int unsigned MAX_WIDTH  = emb_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = emb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [emb_pkg::APB_AW-1:0]  paddr,
    input  wire logic [emb_pkg::APB_DW-1:0]  pwdata,
    output logic      [emb_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [emb_pkg::CH_W-1:0]    red_in,
    input  wire logic [emb_pkg::CH_W-1:0]    green_in,
    input  wire logic [emb_pkg::CH_W-1:0]    blue_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [emb_pkg::CH_W-1:0]    red_out,
    output logic      [emb_pkg::CH_W-1:0]    green_out,
    output logic      [emb_pkg::CH_W-1:0]    blue_out,
    output logic      [emb_pkg::COORD_W-1:0] out_row,
    output logic      [emb_pkg::COORD_W-1:0] out_col,
    output logic                             frame_last
);
    import emb_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    reg_idx_t         reg_sel;
    logic             cfg_wr;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, height_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // effective limits: below 3 counts as 3, above MAX_WIDTH/MAX_HEIGHT as that bound
    logic [LIM_W-1:0] w_eff, h_eff;

    always_comb
    begin
        w_eff = LIM_W'(width_reg);
        if (w_eff < LIM_W'(MIN_DIM))
            w_eff = LIM_W'(MIN_DIM);
        else if (w_eff > LIM_W'(MAX_WIDTH))
            w_eff = LIM_W'(MAX_WIDTH);
        h_eff = LIM_W'(height_reg);
        if (h_eff < LIM_W'(MIN_DIM))
            h_eff = LIM_W'(MIN_DIM);
        else if (h_eff > LIM_W'(MAX_HEIGHT))
            h_eff = LIM_W'(MAX_HEIGHT);
    end

    // ---------------- pipeline control ----------------
    logic clearing;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic en;
    logic accept;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg || clearing;
    assign accept   = in_valid && !in_stall;

    // ---------------- raster counters ----------------
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [LIM_W-1:0] col_inc, row_inc;
    logic             col_end, row_end;
    logic [LIM_W-1:0] row_back, col_back;

    assign col_inc  = LIM_W'(col_reg) + 1'b1;
    assign row_inc  = LIM_W'(row_reg) + 1'b1;
    assign col_end  = col_inc >= w_eff;
    assign row_end  = row_inc >= h_eff;
    assign row_back = LIM_W'(row_reg) - LIM_W'(KDIM - 1);
    assign col_back = LIM_W'(col_reg) - LIM_W'(KDIM - 1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage A: buffer read in flight ----------------
    logic               va_reg;
    pixel_t             pix_a_reg;
    logic [CW-1:0]      addr_a_reg;
    logic               fire_a_reg;
    logic               last_a_reg;
    logic [COORD_W-1:0] row_a_reg, col_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_a_reg  <= {red_in, green_in, blue_in};
            addr_a_reg <= col_reg;
            fire_a_reg <= (row_reg >= RW'(KDIM - 1)) && (col_reg >= CW'(KDIM - 1));
            last_a_reg <= row_end && col_end;
            row_a_reg  <= row_back[COORD_W-1:0];
            col_a_reg  <= col_back[COORD_W-1:0];
        end
    end

    pixel_t rd_older, rd_newer;
    logic   a_move;

    assign a_move = en && va_reg;

    emb_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (en),
        .rd_addr  (col_reg),
        .wr_en    (a_move),
        .wr_addr  (addr_a_reg),
        .wr_older (rd_newer),
        .wr_newer (pix_a_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer),
        .clearing (clearing)
    );

    // ---------------- window: chain of column cells ----------------
    // cell 0 holds the newest column, cell KDIM-1 the oldest
    column_t chain_col [KDIM+1];
    chsum_t  chain_sum [KDIM+1];

    assign chain_col[0] = {rd_older, rd_newer, pix_a_reg};
    assign chain_sum[0] = '0;

    for (genvar i = 0; i < KDIM; i++)
    begin : g_cell
        emb_cell #(
            .KCOL (KDIM - 1 - i)
        ) u_cell (
            .clk      (clk),
            .shift    (a_move),
            .col_in   (chain_col[i]),
            .psum_in  (chain_sum[i]),
            .col_out  (chain_col[i+1]),
            .psum_out (chain_sum[i+1])
        );
    end

    // ---------------- stage B: window complete ----------------
    logic               vb_reg;
    logic               last_b_reg;
    logic [COORD_W-1:0] row_b_reg, col_b_reg;
    result_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg && fire_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_b_reg <= last_a_reg;
            row_b_reg  <= row_a_reg;
            col_b_reg  <= col_a_reg;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < KDIM; ch++)
        begin
            res.pix[ch] = clamp8(chain_sum[KDIM][ch]);
        end
        res.row  = row_b_reg;
        res.col  = col_b_reg;
        res.last = last_b_reg;
    end

    // ---------------- output register with skid ----------------
    result_t main_reg, skid_reg;
    logic    take, push;
    logic    load_main_res, load_main_skid, load_skid;

    assign take = out_valid_reg && !out_stall;
    assign push = en && vb_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main_res   = 1'b0;
        load_main_skid  = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_main_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                load_main_res  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main_res)
            main_reg <= res;
        else if (load_main_skid)
            main_reg <= skid_reg;
        if (load_skid)
            skid_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = main_reg.pix[2];
    assign green_out  = main_reg.pix[1];
    assign blue_out   = main_reg.pix[0];
    assign out_row    = main_reg.row;
    assign out_col    = main_reg.col;
    assign frame_last = main_reg.last;

endmodule

`default_nettype wire

### hdl/emb_checker.sv
`default_nettype none

`include "emboss_3x3_convolution_assert.svh"

module emb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [emb_pkg::CH_W-1:0]    red_out,
    input wire logic [emb_pkg::CH_W-1:0]    green_out,
    input wire logic [emb_pkg::CH_W-1:0]    blue_out,
    input wire logic [emb_pkg::COORD_W-1:0] out_row,
    input wire logic [emb_pkg::COORD_W-1:0] out_col,
    input wire logic                        frame_last
);
    import emb_pkg::*;

    // a stalled result holds
    `EMB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable({red_out, green_out, blue_out, out_row, out_col, frame_last}))

    // backpressure reaches the input only after the output was held
    `EMB_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

    // one taken result frees the skid entry
    `EMB_ASSERT_NEXT(a_stall_release, clk, rst_n, in_stall && out_valid && !out_stall, !in_stall)

    // the input stays open while nothing waits at the output, once the buffers are clear
    `EMB_ASSERT_NEXT(a_no_idle_stall, clk, rst_n, !in_stall && !out_valid, !in_stall)

endmodule

bind emboss_3x3_convolution emb_checker u_emb_checker (.*);

`default_nettype wire

### tb/tb_emboss_3x3_convolution.sv
`default_nettype none

module tb_emboss_3x3_convolution;
    timeunit 1ns;
    timeprecision 1ps;

    import emb_pkg::*;

    localparam int unsigned MAX_W       = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H       = DEF_MAX_HEIGHT;
    localparam int          HOLD_CYCLES = 200;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          SETTLE      = 8;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;
    logic                in_valid = 1'b0;
    wire                 in_stall;
    logic [CH_W-1:0]     red_in   = '0;
    logic [CH_W-1:0]     green_in = '0;
    logic [CH_W-1:0]     blue_in  = '0;
    wire                 out_valid;
    logic                out_stall = 1'b0;
    wire  [CH_W-1:0]     red_out;
    wire  [CH_W-1:0]     green_out;
    wire  [CH_W-1:0]     blue_out;
    wire  [COORD_W-1:0]  out_row;
    wire  [COORD_W-1:0]  out_col;
    wire                 frame_last;

    emboss_3x3_convolution DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pixels waiting to be sent, and embossed pixels waiting to come out
    pixel_t  pixel_q [$];
    result_t embossed_q [$];
    pixel_t  next_px;
    result_t want;
    int      mismatches = 0;

    bit no_idle  = 1'b0;
    int hold_req = 0;
    int hold_seen;
    int hold_left;

    // shadow of the filter state
    pixel_t       older_row [MAX_W];
    pixel_t       newer_row [MAX_W];
    pixel_t       win [6];          // 0..2: col-2 top/mid/bottom, 3..5: col-1
    int unsigned  col_cnt = 0;
    int unsigned  row_cnt = 0;
    logic [CFG_W-1:0] cfg_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_IMAGE_HEIGHT;

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    function automatic int unsigned clip_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic emboss_step(input pixel_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          s;
        int          ch;
        pixel_t      top;
        pixel_t      mid;
        result_t     res;
        w = clip_dim(cfg_width, MAX_W);
        h = clip_dim(cfg_height, MAX_H);
        c = col_cnt;
        r = row_cnt;
        if (c >= MAX_W)
            c = 0;
        top = older_row[c];
        mid = newer_row[c];
        if (r >= 2 && c >= 2)
        begin
            for (ch = 0; ch < 3; ch++)
            begin
                s = -2 * int'(win[0][ch]) - int'(win[3][ch]) - int'(win[1][ch])
                    + int'(win[4][ch]) + int'(mid[ch]) + int'(win[5][ch])
                    + 2 * int'(px[ch]);
                if (s < 0)
                    res.pix[ch] = 8'h00;
                else if (s > 255)
                    res.pix[ch] = 8'hFF;
                else
                    res.pix[ch] = chan_t'(s);
            end
            res.row  = COORD_W'(r - 2);
            res.col  = COORD_W'(c - 2);
            res.last = (r + 1 >= h) && (c + 1 >= w);
            embossed_q.push_back(res);
        end
        older_row[c] = mid;
        newer_row[c] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            c = c + 1;
        col_cnt = c;
        row_cnt = r;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            red_in   <= '0;
            green_in <= '0;
            blue_in  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                emboss_step({red_in, green_in, blue_in});
            if (!in_valid || !in_stall)
            begin
                if (pixel_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 16))
                begin
                    next_px = pixel_q.pop_front();
                    in_valid <= 1'b1;
                    red_in   <= next_px[2];
                    green_in <= next_px[1];
                    blue_in  <= next_px[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (embossed_q.size() == 0)
                report_mismatch("result with none pending", out_col, 0);
            else
            begin
                want = embossed_q.pop_front();
                if (red_out !== want.pix[2])
                    report_mismatch("red_out", red_out, want.pix[2]);
                if (green_out !== want.pix[1])
                    report_mismatch("green_out", green_out, want.pix[1]);
                if (blue_out !== want.pix[0])
                    report_mismatch("blue_out", blue_out, want.pix[0]);
                if (out_row !== want.row)
                    report_mismatch("out_row", out_row, want.row);
                if (out_col !== want.col)
                    report_mismatch("out_col", out_col, want.col);
                if (frame_last !== want.last)
                    report_mismatch("frame_last", frame_last, want.last);
            end
        end
    end

    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
    endtask

    function automatic chan_t rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(input int n);
        repeat (n)
            pixel_q.push_back({rand_chan(), rand_chan(), rand_chan()});
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned hi);
        if ($urandom_range(0, 9) == 0)
            return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(MIN_DIM, hi));
    endfunction

    // sampled on the falling edge so the sender's queue and valid are settled
    task automatic wait_idle(input int settle);
        int guard;
        guard = 0;
        while (pixel_q.size() != 0 || in_valid)
            @(negedge clk);
        while (embossed_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (settle) @(negedge clk);
    endtask

    initial
    begin
        #(6_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        chan_t r;
        chan_t g;
        for (int i = 0; i < MAX_W; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // written while the line buffers are still being cleared
        cfg_write(REG_IMAGE_WIDTH, 12'd4);
        cfg_write(REG_IMAGE_HEIGHT, 12'd4);

        // 4x4 frame: bright top-left block drives the low clamp on red and
        // the high clamp on green; blue ramps through the full range
        for (int k = 0; k < 16; k++)
        begin
            r = ((k % 4) < 2 && k < 8) ? 8'hFF : 8'h00;
            pixel_q.push_back({r, ~r, chan_t'(k * 17)});
        end
        wait_idle(SETTLE);

        // sizes below the minimum behave as 3x3: a single window
        cfg_write(REG_IMAGE_WIDTH, 12'd0);
        cfg_write(REG_IMAGE_HEIGHT, 12'd2);
        for (int k = 0; k < 9; k++)
        begin
            r = (k == 8) ? 8'hFF : 8'h00;
            g = (k == 0) ? 8'hFF : 8'h00;
            pixel_q.push_back({r, g, chan_t'($urandom_range(0, 255))});
        end
        wait_idle(SETTLE);

        // small random frames; writes land mid-frame since counters persist
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_IMAGE_WIDTH, pick_dim(12));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_IMAGE_HEIGHT, pick_dim(8));
            @(negedge clk);
            if (ph == 3)
                hold_req = hold_req + 1;
            queue_pixels($urandom_range(40, 55));
            wait_idle(SETTLE);
        end

        // widest line (oversize value clamps to the maximum), no idling;
        // columns never written before read back as zero
        cfg_write(REG_IMAGE_WIDTH, 12'hFFF);
        cfg_write(REG_IMAGE_HEIGHT, 12'd3);
        @(negedge clk);
        no_idle = 1'b1;
        queue_pixels(100);
        wait_idle(SETTLE);
        no_idle = 1'b0;

        // shrink the width while the column counter is beyond it
        cfg_write(REG_IMAGE_WIDTH, 12'd10);
        cfg_write(REG_IMAGE_HEIGHT, 12'd5);
        @(negedge clk);
        queue_pixels(60);
        wait_idle(SETTLE);

        // tallest frame (oversize value clamps to the maximum), narrowest line
        cfg_write(REG_IMAGE_WIDTH, 12'd3);
        cfg_write(REG_IMAGE_HEIGHT, 12'hFFF);
        @(negedge clk);
        queue_pixels(60);
        wait_idle(20);

        if (embossed_q.size() != 0)
            report_mismatch("results never delivered", 0, embossed_q.size());
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/emb_pkg.sv
hdl/emb_cell.sv
hdl/emb_line_buf.sv
hdl/emboss_3x3_convolution.sv
hdl/emb_checker.sv
tb/tb_emboss_3x3_convolution.sv
